// ===== rtl/rpq_pkg.sv =====
`timescale 1ns / 1ps
// rpq_pkg: shared widths, status codes, defaults and the control struct of the
// request priority queue. No dependencies.
package rpq_pkg;

    localparam int LBA_W     = 64;
    localparam int SEC_W     = 32;
    localparam int PRIO_IN_W = 8;
    localparam int OCC_W     = 5;
    localparam int LIMIT_W   = 5;
    localparam int STATUS_W  = 2;

    localparam int DEPTH_DEF     = 16;
    localparam int PRIO_BITS_DEF = 8;
    localparam int LIMIT_RESET   = 16;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2
    } rpq_status_t;

    typedef enum logic {
        OP_PUSH = 1'b0,
        OP_POP  = 1'b1
    } rpq_op_t;

    // per-cycle control of the shared priority comparator
    typedef struct packed {
        logic en;     // a candidate slot is presented this cycle
        logic first;  // candidate is slot 0: take it unconditionally
    } rpq_scan_ctl_t;

endpackage

// ===== rtl/rpq_if.sv =====
`timescale 1ns / 1ps
// rpq_req_if / rpq_rsp_if: valid/ready request and response channels.
// Depends on rpq_pkg for field widths.
interface rpq_req_if;
    logic                           valid;
    logic                           ready;
    logic                           op;
    logic [rpq_pkg::LBA_W-1:0]      req_lba;
    logic [rpq_pkg::SEC_W-1:0]      req_sectors;
    logic [rpq_pkg::PRIO_IN_W-1:0]  req_prio;
    logic                           req_is_write;

    modport source (output valid, op, req_lba, req_sectors, req_prio, req_is_write,
                    input ready);
    modport sink   (input valid, op, req_lba, req_sectors, req_prio, req_is_write,
                    output ready);
endinterface

interface rpq_rsp_if;
    logic                           valid;
    logic                           ready;
    logic [rpq_pkg::STATUS_W-1:0]   status;
    logic [rpq_pkg::LBA_W-1:0]      out_lba;
    logic [rpq_pkg::SEC_W-1:0]      out_sectors;
    logic [rpq_pkg::PRIO_IN_W-1:0]  out_prio;
    logic                           out_is_write;
    logic [rpq_pkg::OCC_W-1:0]      occupancy;

    modport source (output valid, status, out_lba, out_sectors, out_prio, out_is_write,
                    occupancy, input ready);
    modport sink   (input valid, status, out_lba, out_sectors, out_prio, out_is_write,
                    occupancy, output ready);
endinterface

// ===== rtl/rpq_slot_mem.sv =====
`timescale 1ns / 1ps
// rpq_slot_mem: slot storage, one write port and one registered read port.
// No dependencies.
module rpq_slot_mem #(
    parameter int DEPTH  = 16,
    parameter int WIDTH  = 8,
    parameter int ADDR_W = 4
) (
    input  logic              clk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [WIDTH-1:0]  wr_data,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [WIDTH-1:0]  rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== rtl/rpq_max_scan.sv =====
`timescale 1ns / 1ps
// rpq_max_scan: shared priority comparator with running best slot/priority.
// Depends on rpq_pkg for the control struct.
module rpq_max_scan #(
    parameter int ADDR_W = 4,
    parameter int PRIO_W = 8
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  rpq_pkg::rpq_scan_ctl_t ctl,
    input  logic [ADDR_W-1:0]     cand_idx,
    input  logic [PRIO_W-1:0]     cand_prio,
    output logic                  take,
    output logic [ADDR_W-1:0]     best_idx,
    output logic [PRIO_W-1:0]     best_prio
);

    logic [ADDR_W-1:0] best_idx_reg;
    logic [PRIO_W-1:0] best_prio_reg;

    // strictly greater keeps the lowest slot on ties
    assign take = ctl.en && (ctl.first || (cand_prio > best_prio_reg));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            best_idx_reg <= '0;
        end
        else if (take)
        begin
            best_idx_reg <= cand_idx;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            best_prio_reg <= cand_prio;
        end
    end

    assign best_idx  = best_idx_reg;
    assign best_prio = best_prio_reg;

endmodule

// ===== rtl/request_priority_queue.sv =====
`timescale 1ns / 1ps
// request_priority_queue: unsorted-array priority queue of block I/O requests.
// Depends on rpq_pkg, rpq_if, rpq_slot_mem and rpq_max_scan.
//
//  channel     | dir | handshake       | content
//  ------------+-----+-----------------+-------------------------------------
//  req_ch      | in  | valid / ready   | op, lba, sectors, prio, write flag
//  rsp_ch      | out | valid / ready   | status, popped request, occupancy
//  cfg_wr_*    | in  | write enable    | queue_limit (5 bits), no read-back
//
//  Push and refused pop: the result is registered and shown the cycle after accept.
//  Pop: one slot is read per cycle from the single read port of the slot
//  memory and fed to the one priority comparator, then the last slot is
//  moved into the gap once the response register is free.
//  Reset clears the count and sets the limit to 16; slot contents are left.
//  A new request is taken only in idle, with the response register free or
//  being drained in the same cycle; a stalled response holds its value.
module request_priority_queue #(
    parameter int DEPTH     = rpq_pkg::DEPTH_DEF,
    parameter int PRIO_BITS = rpq_pkg::PRIO_BITS_DEF
) (
    input  logic                         clk,
    input  logic                         rst_n,
    rpq_req_if.sink                      req_ch,
    rpq_rsp_if.source                    rsp_ch,
    input  logic                         cfg_wr_en,
    input  logic [rpq_pkg::LIMIT_W-1:0]  cfg_wr_data
);

    // stored priority keeps only the low PRIO_BITS bits of the 8-bit field
    localparam int PW     = (PRIO_BITS < rpq_pkg::PRIO_IN_W) ? PRIO_BITS
                                                             : rpq_pkg::PRIO_IN_W;
    localparam int AW     = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW     = $clog2(DEPTH + 1);
    localparam int CMPW   = (CW > rpq_pkg::LIMIT_W) ? CW : rpq_pkg::LIMIT_W;
    // slot word layout: {write, prio, sectors, lba}
    localparam int SEC_LO = rpq_pkg::LBA_W;
    localparam int PRI_LO = SEC_LO + rpq_pkg::SEC_W;
    localparam int WR_BIT = PRI_LO + PW;
    localparam int WORD_W = WR_BIT + 1;

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_SCAN = 3'b010,
        S_DONE = 3'b100
    } state_t;

    state_t state_reg, state_next;

    logic [CW-1:0]                  count_reg, count_next;
    logic [rpq_pkg::LIMIT_W-1:0]    limit_reg;
    logic [CW-1:0]                  idx_reg, idx_next;       // next slot to read
    logic                           cmp_valid_reg, cmp_valid_next;
    logic [AW-1:0]                  cmp_idx_reg, cmp_idx_next; // slot in rd_data
    logic [WORD_W-1:0]              best_word_reg, last_word_reg;

    // response register
    logic                           rsp_valid_reg, rsp_valid_next;
    rpq_pkg::rpq_status_t           status_reg, status_next;
    logic [rpq_pkg::LBA_W-1:0]      lba_reg, lba_next;
    logic [rpq_pkg::SEC_W-1:0]      sec_reg, sec_next;
    logic [rpq_pkg::PRIO_IN_W-1:0]  prio_reg, prio_next;
    logic                           wr_reg, wr_next;
    logic [rpq_pkg::OCC_W-1:0]      occ_reg, occ_next;

    // memory and comparator hookup
    logic                           mem_we;
    logic [AW-1:0]                  mem_waddr, mem_raddr;
    logic [WORD_W-1:0]              mem_wdata, mem_rdata;
    rpq_pkg::rpq_scan_ctl_t         scan_ctl;
    logic                           scan_take;
    logic [AW-1:0]                  best_idx;
    logic [PW-1:0]                  best_prio;

    logic                           rsp_free;
    logic                           accept;
    logic                           full;
    logic                           last_cmp;

    assign rsp_free     = !rsp_valid_reg || rsp_ch.ready;
    assign req_ch.ready = (state_reg == S_IDLE) && rsp_free;
    assign accept       = req_ch.valid && req_ch.ready;

    // full when count reaches the limit, or the array itself (limit saturates)
    assign full = (CMPW'(count_reg) >= CMPW'(limit_reg)) || (count_reg == CW'(DEPTH));

    assign last_cmp = cmp_valid_reg && (CW'(cmp_idx_reg) == (count_reg - CW'(1)));

    assign scan_ctl.en    = cmp_valid_reg;
    assign scan_ctl.first = (cmp_idx_reg == '0);

    rpq_slot_mem #(
        .DEPTH  (DEPTH),
        .WIDTH  (WORD_W),
        .ADDR_W (AW)
    ) u_mem (
        .clk     (clk),
        .wr_en   (mem_we),
        .wr_addr (mem_waddr),
        .wr_data (mem_wdata),
        .rd_addr (mem_raddr),
        .rd_data (mem_rdata)
    );

    rpq_max_scan #(
        .ADDR_W (AW),
        .PRIO_W (PW)
    ) u_scan (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctl       (scan_ctl),
        .cand_idx  (cmp_idx_reg),
        .cand_prio (mem_rdata[WR_BIT-1:PRI_LO]),
        .take      (scan_take),
        .best_idx  (best_idx),
        .best_prio (best_prio)
    );

    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        idx_next       = idx_reg;
        cmp_valid_next = 1'b0;
        cmp_idx_next   = cmp_idx_reg;
        mem_we         = 1'b0;
        mem_waddr      = count_reg[AW-1:0];
        mem_wdata      = {req_ch.req_is_write, req_ch.req_prio[PW-1:0],
                          req_ch.req_sectors, req_ch.req_lba};
        mem_raddr      = idx_reg[AW-1:0];

        rsp_valid_next = rsp_valid_reg && !rsp_ch.ready;
        status_next    = status_reg;
        lba_next       = lba_reg;
        sec_next       = sec_reg;
        prio_next      = prio_reg;
        wr_next        = wr_reg;
        occ_next       = occ_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    rsp_valid_next = 1'b1;
                    lba_next       = '0;
                    sec_next       = '0;
                    prio_next      = '0;
                    wr_next        = 1'b0;
                    status_next    = rpq_pkg::ST_OK;
                    if (req_ch.op == rpq_pkg::OP_PUSH)
                    begin
                        if (full)
                        begin
                            status_next = rpq_pkg::ST_FULL;
                        end
                        else
                        begin
                            mem_we     = 1'b1;
                            count_next = count_reg + CW'(1);
                        end
                        occ_next = rpq_pkg::OCC_W'(count_next);
                    end
                    else if (count_reg == '0)
                    begin
                        status_next = rpq_pkg::ST_EMPTY;
                        occ_next    = '0;
                    end
                    else
                    begin
                        // pop: response comes from the scan
                        rsp_valid_next = 1'b0;
                        idx_next       = '0;
                        state_next     = S_SCAN;
                    end
                end
            end
            S_SCAN:
            begin
                // issue one read per cycle, compare the previous one
                if (idx_reg < count_reg)
                begin
                    cmp_valid_next = 1'b1;
                    cmp_idx_next   = idx_reg[AW-1:0];
                    idx_next       = idx_reg + CW'(1);
                end
                if (last_cmp)
                begin
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                if (rsp_free)
                begin
                    // move the last slot into the vacated one
                    mem_we         = 1'b1;
                    mem_waddr      = best_idx;
                    mem_wdata      = last_word_reg;
                    count_next     = count_reg - CW'(1);
                    rsp_valid_next = 1'b1;
                    status_next    = rpq_pkg::ST_OK;
                    lba_next       = best_word_reg[SEC_LO-1:0];
                    sec_next       = best_word_reg[PRI_LO-1:SEC_LO];
                    prio_next      = rpq_pkg::PRIO_IN_W'(best_prio);
                    wr_next        = best_word_reg[WR_BIT];
                    occ_next       = rpq_pkg::OCC_W'(count_next);
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            limit_reg     <= rpq_pkg::LIMIT_W'(rpq_pkg::LIMIT_RESET);
            idx_reg       <= '0;
            cmp_valid_reg <= 1'b0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            idx_reg       <= idx_next;
            cmp_valid_reg <= cmp_valid_next;
            rsp_valid_reg <= rsp_valid_next;
            if (cfg_wr_en)
            begin
                limit_reg <= cfg_wr_data;
            end
        end
    end

    // payload registers, no reset
    always_ff @(posedge clk)
    begin
        cmp_idx_reg <= cmp_idx_next;
        status_reg  <= status_next;
        lba_reg     <= lba_next;
        sec_reg     <= sec_next;
        prio_reg    <= prio_next;
        wr_reg      <= wr_next;
        occ_reg     <= occ_next;
        if (scan_take)
        begin
            best_word_reg <= mem_rdata;
        end
        if (last_cmp)
        begin
            last_word_reg <= mem_rdata;
        end
    end

    assign rsp_ch.valid        = rsp_valid_reg;
    assign rsp_ch.status       = status_reg;
    assign rsp_ch.out_lba      = lba_reg;
    assign rsp_ch.out_sectors  = sec_reg;
    assign rsp_ch.out_prio     = prio_reg;
    assign rsp_ch.out_is_write = wr_reg;
    assign rsp_ch.occupancy    = occ_reg;

endmodule

// ===== tb/tb.sv =====
`timescale 1ns / 1ps
// tb: self-checking testbench of request_priority_queue, driven through the
// rpq_req_if / rpq_rsp_if channels. Depends on rpq_pkg, rpq_if and the block.
module tb;
    import rpq_pkg::*;

    localparam int DEPTH       = DEPTH_DEF;
    // Wait covers the longest pop over DEPTH slots; leave room for the response register.
    localparam int QUIET_TICKS = DEPTH + 12;
    localparam int REPORT_MAX  = 10;

    // One response as the queue reports it.
    typedef struct packed {
        rpq_status_t            status;
        logic [LBA_W-1:0]       lba;
        logic [SEC_W-1:0]       sectors;
        logic [PRIO_IN_W-1:0]   prio;
        logic                   wr_flag;
        logic [OCC_W-1:0]       occupancy;
    } queue_result_t;

    logic clk;
    logic rst_n;
    logic cfg_wr_en;
    logic [LIMIT_W-1:0] cfg_wr_data;

    rpq_req_if req_ch ();
    rpq_rsp_if rsp_ch ();

    request_priority_queue i_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .req_ch      (req_ch),
        .rsp_ch      (rsp_ch),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data)
    );

    // ------------------------------------------------------------------
    // Shadow copy of the queue: slot array, occupancy and limit register.
    // Updated when a request is accepted, so it runs ahead of the block.
    // ------------------------------------------------------------------
    logic [LBA_W-1:0]     shadow_lba     [DEPTH];
    logic [SEC_W-1:0]     shadow_sectors [DEPTH];
    logic [PRIO_IN_W-1:0] shadow_prio    [DEPTH];
    logic                 shadow_write   [DEPTH];
    int unsigned          shadow_count;
    logic [LIMIT_W-1:0]   shadow_limit;

    // Responses still owed by the block, oldest first.
    queue_result_t owed_responses [$];

    int  mismatch_count;
    bit  steady;             // suppresses random idling on both sides
    int  stall_request;      // hold-off length handed to the receiver
    int  stall_left;

    // ------------------------------------------------------------------
    // Clock and reset
    // ------------------------------------------------------------------
    initial
    begin
        clk = 1'b0;
        forever
        begin
            #1 clk = ~clk;
        end
    end

    // Run limit, far beyond the slowest legal run.
    initial
    begin
        #2_000_000;
        $display("Test completed with failures");
        $finish;
    end

    // ------------------------------------------------------------------
    // Prediction: applies one request to the shadow queue and returns the
    // response it must produce.
    // ------------------------------------------------------------------
    function automatic queue_result_t apply_queue_request(
        rpq_op_t                op,
        logic [LBA_W-1:0]       lba,
        logic [SEC_W-1:0]       sectors,
        logic [PRIO_IN_W-1:0]   prio,
        logic                   wr_flag
    );
        queue_result_t res;
        int unsigned   cap;
        int unsigned   best;
        int unsigned   last;
        res = '0;
        res.status = ST_OK;
        // limit saturates at the slot count; zero refuses every push
        cap = (shadow_limit > DEPTH) ? DEPTH : shadow_limit;
        if (op == OP_PUSH)
        begin
            if (shadow_count >= cap)
            begin
                res.status = ST_FULL;
            end
            else
            begin
                shadow_lba[shadow_count]     = lba;
                shadow_sectors[shadow_count] = sectors;
                shadow_prio[shadow_count]    = prio;
                shadow_write[shadow_count]   = wr_flag;
                shadow_count++;
            end
        end
        else if (shadow_count == 0)
        begin
            res.status = ST_EMPTY;
        end
        else
        begin
            // strict greater-than keeps the lowest slot on equal priority
            best = 0;
            for (int unsigned i = 1; i < shadow_count; i++)
            begin
                if (shadow_prio[i] > shadow_prio[best])
                begin
                    best = i;
                end
            end
            res.lba      = shadow_lba[best];
            res.sectors  = shadow_sectors[best];
            res.prio     = shadow_prio[best];
            res.wr_flag  = shadow_write[best];
            // last occupied slot fills the gap
            last = shadow_count - 1;
            shadow_lba[best]     = shadow_lba[last];
            shadow_sectors[best] = shadow_sectors[last];
            shadow_prio[best]    = shadow_prio[last];
            shadow_write[best]   = shadow_write[last];
            shadow_count = last;
        end
        res.occupancy = shadow_count[OCC_W-1:0];
        return res;
    endfunction

    // ------------------------------------------------------------------
    // Request side: one request per call, driven at the falling edge and
    // taken at the first rising edge with valid and ready both high.
    // ------------------------------------------------------------------
    task automatic send_request(
        rpq_op_t                op,
        logic [LBA_W-1:0]       lba,
        logic [SEC_W-1:0]       sectors,
        logic [PRIO_IN_W-1:0]   prio,
        logic                   wr_flag
    );
        while (!steady && $urandom_range(0, 99) < 11)
        begin
            req_ch.valid = 1'b0;
            @(negedge clk);
        end
        req_ch.valid        = 1'b1;
        req_ch.op           = op;
        req_ch.req_lba      = lba;
        req_ch.req_sectors  = sectors;
        req_ch.req_prio     = prio;
        req_ch.req_is_write = wr_flag;
        do
        begin
            @(posedge clk);
        end
        while (!req_ch.ready);
        owed_responses.push_back(apply_queue_request(op, lba, sectors, prio, wr_flag));
        @(negedge clk);
        req_ch.valid = 1'b0;
    endtask

    // Random priority: small values to force ties, the extremes, or anything.
    function automatic logic [PRIO_IN_W-1:0] pick_prio();
        case ($urandom_range(0, 3))
            0:       return PRIO_IN_W'($urandom_range(0, 3));
            1:       return $urandom_range(0, 1) ? '1 : '0;
            default: return PRIO_IN_W'($urandom());
        endcase
    endfunction

    task automatic send_random_request(int push_pct);
        rpq_op_t op;
        op = ($urandom_range(0, 99) < push_pct) ? OP_PUSH : OP_POP;
        send_request(op, {$urandom(), $urandom()}, $urandom(), pick_prio(),
                     1'($urandom_range(0, 1)));
    endtask

    // Block is idle once every response is in and the longest pop has passed.
    task automatic wait_queue_idle();
        while (owed_responses.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (QUIET_TICKS) @(posedge clk);
        @(negedge clk);
    endtask

    task automatic write_queue_limit(logic [LIMIT_W-1:0] limit);
        wait_queue_idle();
        cfg_wr_en    = 1'b1;
        cfg_wr_data  = limit;
        shadow_limit = limit;
        @(negedge clk);
        cfg_wr_en = 1'b0;
    endtask

    // ------------------------------------------------------------------
    // Response side: ready with random idling and an optional long
    // hold-off counted here, so the queue backs up into the request side.
    // ------------------------------------------------------------------
    initial
    begin
        rsp_ch.ready = 1'b0;
        stall_left   = 0;
        forever
        begin
            @(negedge clk);
            if (stall_request > 0)
            begin
                stall_left    = stall_request;
                stall_request = 0;
            end
            if (stall_left > 0)
            begin
                rsp_ch.ready = 1'b0;
                stall_left--;
            end
            else
            begin
                rsp_ch.ready = steady || ($urandom_range(0, 99) >= 11);
            end
        end
    end

    // Compare every accepted response with the oldest owed one.
    always @(posedge clk)
    begin
        queue_result_t got;
        queue_result_t want;
        if (rst_n && rsp_ch.valid && rsp_ch.ready)
        begin
            got.status    = rpq_status_t'(rsp_ch.status);
            got.lba       = rsp_ch.out_lba;
            got.sectors   = rsp_ch.out_sectors;
            got.prio      = rsp_ch.out_prio;
            got.wr_flag   = rsp_ch.out_is_write;
            got.occupancy = rsp_ch.occupancy;
            if (owed_responses.size() == 0)
            begin
                mismatch_count++;
                if (mismatch_count <= REPORT_MAX)
                begin
                    $display("%0t: response with none owed: status %0d occ %0d",
                             $realtime, got.status, got.occupancy);
                end
            end
            else
            begin
                want = owed_responses.pop_front();
                if (got.status !== want.status || got.lba !== want.lba ||
                    got.sectors !== want.sectors || got.prio !== want.prio ||
                    got.wr_flag !== want.wr_flag || got.occupancy !== want.occupancy)
                begin
                    mismatch_count++;
                    if (mismatch_count <= REPORT_MAX)
                    begin
                        $display("%0t: response mismatch", $realtime);
                        $display("  expected status %0d lba %h sec %h prio %0d wr %b occ %0d",
                                 want.status, want.lba, want.sectors, want.prio,
                                 want.wr_flag, want.occupancy);
                        $display("  actual   status %0d lba %h sec %h prio %0d wr %b occ %0d",
                                 got.status, got.lba, got.sectors, got.prio,
                                 got.wr_flag, got.occupancy);
                    end
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Empty pop, field extremes, equal-priority order and slot compaction.
    task automatic test_order_and_extremes();
        send_request(OP_POP, '1, '1, '1, 1'b1);           // empty queue refuses
        send_request(OP_PUSH, '1, '1, '1, 1'b1);          // slot 0, prio max
        send_request(OP_PUSH, '0, '0, '0, 1'b0);          // slot 1, prio 0
        send_request(OP_PUSH, 64'h0123_4567_89ab_cdef, 32'h5a5a_a5a5, 8'd9, 1'b0);
        send_request(OP_PUSH, 64'hfedc_ba98_7654_3210, 32'ha5a5_5a5a, '1, 1'b1);
        // tie at max: slot 0 wins, slot 3 moves into slot 0 and wins next
        repeat (4) send_request(OP_POP, '0, '0, '0, 1'b0);
        send_request(OP_POP, '0, '0, '0, 1'b0);           // empty again
    endtask

    // Limit of zero refuses every push; limit of one holds one request.
    task automatic test_small_limits();
        write_queue_limit(5'd0);
        send_request(OP_PUSH, {$urandom(), $urandom()}, $urandom(), 8'd7, 1'b1);
        send_request(OP_POP, '0, '0, '0, 1'b0);
        write_queue_limit(5'd1);
        send_request(OP_PUSH, {$urandom(), $urandom()}, $urandom(), 8'd3, 1'b1);
        send_request(OP_PUSH, {$urandom(), $urandom()}, $urandom(), 8'd200, 1'b0);
        repeat (2) send_request(OP_POP, '0, '0, '0, 1'b0);
    endtask

    // Alternating fill-heavy and drain-heavy bursts, so the queue reaches
    // both its limit and empty under a given limit setting.
    task automatic test_random_traffic(logic [LIMIT_W-1:0] limit, int count, bit no_idle);
        write_queue_limit(limit);
        steady = no_idle;
        for (int k = 0; k < count; k++)
        begin
            send_random_request(((k / 24) % 2 == 0) ? 80 : 25);
        end
        steady = 1'b0;
    endtask

    // Receiver holds off for a long stretch while requests keep coming.
    task automatic test_response_backpressure();
        write_queue_limit(5'd8);
        stall_request = 400;
        for (int k = 0; k < 60; k++)
        begin
            send_random_request((k < 40) ? 75 : 20);
        end
    endtask

    initial
    begin
        rst_n               = 1'b0;
        cfg_wr_en           = 1'b0;
        cfg_wr_data         = '0;
        req_ch.valid        = 1'b0;
        req_ch.op           = OP_PUSH;
        req_ch.req_lba      = '0;
        req_ch.req_sectors  = '0;
        req_ch.req_prio     = '0;
        req_ch.req_is_write = 1'b0;
        mismatch_count      = 0;
        steady              = 1'b0;
        stall_request       = 0;
        shadow_count        = 0;
        shadow_limit        = LIMIT_W'(LIMIT_RESET);

        repeat (9) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        test_order_and_extremes();
        test_small_limits();
        test_random_traffic(5'd31, 300, 1'b0);   // saturates at DEPTH
        test_random_traffic(5'd16, 300, 1'b1);   // long run with no idling
        test_random_traffic(5'd0, 40, 1'b0);
        test_random_traffic(5'd1, 120, 1'b0);
        test_random_traffic(5'd17, 250, 1'b0);
        test_response_backpressure();
        repeat (5)
        begin
            test_random_traffic(LIMIT_W'($urandom_range(0, 31)), 150, 1'b0);
        end

        // drain, then let any trailing pop finish
        while (owed_responses.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (QUIET_TICKS) @(posedge clk);

        if (mismatch_count == 0 && owed_responses.size() == 0)
        begin
            $display("Test completed successfully");
        end
        else
        begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
